@@ src/byte_ring_fifo_with_lookahead_macros.svh @@
// Assertion macros used by the byte ring FIFO top level.
`ifndef BYTE_RING_FIFO_WITH_LOOKAHEAD_MACROS_SVH
`define BYTE_RING_FIFO_WITH_LOOKAHEAD_MACROS_SVH
`ifndef SYNTHESIS
`define BRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BRF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BRF_ASSERT(lbl, prop, msg)
`define BRF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ src/brf_pkg.sv @@
// Constants, codes and types of the byte ring FIFO with lookahead.
package brf_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned CNT_W   = $clog2(MAX_RUN + 1);
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned FILL_W  = 10;
  localparam int unsigned FREE_W  = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH     = 3'd0,
    FN_POP      = 3'd1,
    FN_LA_READ  = 3'd2,
    FN_LA_FRONT = 3'd3,
    FN_LA_ADV   = 3'd4,
    FN_COMMIT   = 3'd5,
    FN_PEEK_RUN = 3'd6,
    FN_POP_RUN  = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ src/brf_if.sv @@
// Request and result channel interfaces of the byte ring FIFO.
interface brf_req_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] data_in;
  logic [LEN_W-1:0]  run_length;

  modport source (output valid, func, data_in, run_length, input ready);
  modport sink (input valid, func, data_in, run_length, output ready);
endinterface

interface brf_rsp_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              status;
  logic [FILL_W-1:0] fill_count;
  logic [FREE_W-1:0] free_space;
  logic              last;

  modport source (output valid, data_out, status, fill_count, free_space, last, input ready);
  modport sink (input valid, data_out, status, fill_count, free_space, last, output ready);
endinterface

@@ src/brf_store.sv @@
// Byte store: synchronous memory with registered read and a zeroing sweep after reset.
module brf_store import brf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              busy_q, busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;

  always_comb begin
    clr_addr_d = clr_addr_q + ADDR_W'(1);
    busy_d     = busy_q && (clr_addr_q != ADDR_W'(DEPTH - 1));
    if (busy_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we    = req_i.we;
      waddr = req_i.waddr;
      wdata = req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re && !busy_q) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

@@ src/byte_ring_fifo_with_lookahead.sv @@
// Top level of the byte ring FIFO with lookahead pointer.
//
//   Channel  Direction  Carries
//   in_i     sink       func, data_in, run_length
//   out_o    source     data_out, status, fill_count, free_space, last
//
// Operations that read no byte register their result in the cycle after the transaction;
// the next one can follow in the next cycle if the result is taken or none is waiting.
// A pop, lookahead read or run of n bytes moves one byte per cycle while the output takes them,
// through the single read port of the store, via its read register and then the result register.
// After reset the store is zeroed in a sweep over every address; no item is taken meanwhile.
// A stalled result holds the block; nothing is lost while the output waits.
module byte_ring_fifo_with_lookahead import brf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  brf_req_if.sink   in_i,
  brf_rsp_if.source out_o
);

`include "byte_ring_fifo_with_lookahead_macros.svh"

  state_e            st_q, st_d;
  logic [ADDR_W-1:0] rd_q, rd_d, wr_q, wr_d, la_q, la_d, ptr_q, ptr_d;
  logic [CNT_W-1:0]  icnt_q, icnt_d, ecnt_q, ecnt_d;
  logic              rd_pend_q, rd_pend_d;
  func_e             op_q, op_d, fn;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_err_q, out_err_d;
  logic [FILL_W-1:0] out_fill_q, out_fill_d;
  logic [FREE_W-1:0] out_free_q, out_free_d;
  logic              out_last_q, out_last_d;

  mem_req_t          mreq;
  logic              mem_busy;
  logic [DATA_W-1:0] mem_rdata;

  logic              in_hs, out_free, out_load, start_run, load, issue, len_bad, err;
  logic [CNT_W-1:0]  run_n;
  logic [ADDR_W-1:0] fill_cur, fill_new;

  brf_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .busy_o (mem_busy),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: if (!mem_busy) st_d = ST_IDLE;
      ST_IDLE:  if (in_hs && start_run) st_d = ST_RUN;
      ST_RUN:   if (load && (ecnt_q == CNT_W'(1))) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fn          = func_e'(in_i.func);
    out_free    = !out_valid_q || out_o.ready;
    in_i.ready  = (st_q == ST_IDLE) && out_free;
    in_hs       = in_i.valid && in_i.ready;
    fill_cur    = wr_q - rd_q;
    len_bad     = (in_i.run_length == '0) || (in_i.run_length > LEN_W'(MAX_RUN));

    rd_d        = rd_q;
    wr_d        = wr_q;
    la_d        = la_q;
    ptr_d       = ptr_q;
    icnt_d      = icnt_q;
    ecnt_d      = ecnt_q;
    op_d        = op_q;
    start_run   = 1'b0;
    run_n       = CNT_W'(1);
    err         = 1'b0;
    out_load    = 1'b0;
    out_data_d  = '0;
    out_last_d  = 1'b1;
    load        = 1'b0;
    issue       = 1'b0;
    mreq        = '0;

    if (st_q == ST_IDLE) begin
      unique case (fn)
        FN_PUSH: begin
          if (wr_q + ADDR_W'(1) == rd_q) begin
            err = 1'b1;
          end else begin
            mreq.we    = in_hs;
            mreq.waddr = wr_q;
            mreq.wdata = in_i.data_in;
            wr_d       = wr_q + ADDR_W'(1);
          end
        end
        FN_POP, FN_LA_READ: begin
          if (wr_q == rd_q) err = 1'b1;
          else start_run = 1'b1;
        end
        FN_LA_FRONT: la_d = rd_q;
        FN_LA_ADV:   la_d = la_q + ADDR_W'(1);
        FN_COMMIT:   rd_d = la_q;
        FN_PEEK_RUN: begin
          if (len_bad) begin
            err = 1'b1;
          end else begin
            start_run = 1'b1;
            run_n     = CNT_W'(in_i.run_length);
          end
        end
        FN_POP_RUN: begin
          if (len_bad || (fill_cur < ADDR_W'(in_i.run_length))) begin
            err = 1'b1;
          end else begin
            start_run = 1'b1;
            run_n     = CNT_W'(in_i.run_length);
          end
        end
        default: err = 1'b1;
      endcase
      if (start_run) begin
        op_d   = fn;
        icnt_d = run_n;
        ecnt_d = run_n;
        ptr_d  = ((fn == FN_POP) || (fn == FN_POP_RUN)) ? rd_q : la_q;
        rd_d   = rd_q;
        la_d   = la_q;
      end
      out_load = in_hs && !start_run;
      if (!in_hs) begin
        rd_d = rd_q;
        wr_d = wr_q;
        la_d = la_q;
      end
    end else if (st_q == ST_RUN) begin
      load  = rd_pend_q && out_free;
      issue = (icnt_q != '0) && (!rd_pend_q || out_free);
      mreq.re    = issue;
      mreq.raddr = ptr_q;
      if (issue) begin
        ptr_d  = ptr_q + ADDR_W'(1);
        icnt_d = icnt_q - CNT_W'(1);
      end
      if (load) begin
        out_load   = 1'b1;
        out_data_d = mem_rdata;
        out_last_d = (ecnt_q == CNT_W'(1));
        ecnt_d     = ecnt_q - CNT_W'(1);
        if ((op_q == FN_POP) || (op_q == FN_POP_RUN)) rd_d = rd_q + ADDR_W'(1);
        if (op_q == FN_LA_READ) la_d = la_q + ADDR_W'(1);
      end
    end

    rd_pend_d   = issue || (rd_pend_q && !load);
    fill_new    = wr_d - rd_d;
    out_err_d   = err;
    out_fill_d  = FILL_W'(fill_new);
    out_free_d  = FREE_W'(DEPTH) - FREE_W'(fill_new);
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      rd_q        <= '0;
      wr_q        <= '0;
      la_q        <= '0;
      icnt_q      <= '0;
      ecnt_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      la_q        <= la_d;
      icnt_q      <= icnt_d;
      ecnt_q      <= ecnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    op_q  <= op_d;
    if (out_load) begin
      out_data_q <= out_data_d;
      out_err_q  <= out_err_d;
      out_fill_q <= out_fill_d;
      out_free_q <= out_free_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_out   = out_data_q;
  assign out_o.status     = out_err_q;
  assign out_o.fill_count = out_fill_q;
  assign out_o.free_space = out_free_q;
  assign out_o.last       = out_last_q;

  `BRF_ASSERT(a_pend_in_run, rd_pend_q |-> st_q == ST_RUN, "Read pending outside a run.")
  `BRF_ASSERT(a_run_counts, st_q == ST_RUN |-> ecnt_q == icnt_q + CNT_W'(rd_pend_q),
              "Run counters out of step with the pending read.")
  `BRF_ASSERT(a_run_nonzero, st_q == ST_RUN |-> ecnt_q != '0, "Run state with nothing to emit.")
  `BRF_ASSERT(a_clear_blocks, mem_busy |-> !in_i.ready, "Transaction taken during store clear.")
  `BRF_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_o.valid, "Result valid during reset.")

endmodule

@@ test/brf_checker.sv @@
// Checker that mirrors the byte ring FIFO state and compares every result transaction.
module brf_checker import brf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  brf_req_if                req_i,
  brf_rsp_if                rsp_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output logic [FILL_W-1:0] fill_o
);

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              status;
    logic [FILL_W-1:0] fill_count;
    logic [FREE_W-1:0] free_space;
    logic              last;
  } result_t;

  logic [DATA_W-1:0] mirror_mem [DEPTH];
  logic [ADDR_W-1:0] front_ix;
  logic [ADDR_W-1:0] tail_ix;
  logic [ADDR_W-1:0] look_ix;
  result_t           expected_q [$];
  result_t           oldest;
  int unsigned       error_cnt = 0;

  function automatic logic [FILL_W-1:0] stored_bytes();
    return FILL_W'(tail_ix - front_ix);
  endfunction

  task automatic queue_result(input logic [DATA_W-1:0] data, input logic err, input logic fin);
    result_t r;
    r.data_out   = data;
    r.status     = err;
    r.fill_count = stored_bytes();
    r.free_space = FREE_W'(DEPTH - stored_bytes());
    r.last       = fin;
    expected_q.push_back(r);
  endtask

  task automatic predict_op(input func_e f, input logic [DATA_W-1:0] din,
                            input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] p;
    logic              empty;
    int                i;
    empty = (tail_ix == front_ix);
    case (f)
      FN_PUSH: begin
        if (ADDR_W'(tail_ix + 1'b1) == front_ix) begin
          queue_result('0, 1'b1, 1'b1);
        end else begin
          mirror_mem[tail_ix] = din;
          tail_ix = tail_ix + 1'b1;
          queue_result('0, 1'b0, 1'b1);
        end
      end
      FN_POP: begin
        if (empty) begin
          queue_result('0, 1'b1, 1'b1);
        end else begin
          p = front_ix;
          front_ix = front_ix + 1'b1;
          queue_result(mirror_mem[p], 1'b0, 1'b1);
        end
      end
      FN_LA_READ: begin
        if (empty) begin
          queue_result('0, 1'b1, 1'b1);
        end else begin
          p = look_ix;
          look_ix = look_ix + 1'b1;
          queue_result(mirror_mem[p], 1'b0, 1'b1);
        end
      end
      FN_LA_FRONT: begin
        look_ix = front_ix;
        queue_result('0, 1'b0, 1'b1);
      end
      FN_LA_ADV: begin
        look_ix = look_ix + 1'b1;
        queue_result('0, 1'b0, 1'b1);
      end
      FN_COMMIT: begin
        front_ix = look_ix;
        queue_result('0, 1'b0, 1'b1);
      end
      FN_PEEK_RUN: begin
        if (len == 0 || len > MAX_RUN) begin
          queue_result('0, 1'b1, 1'b1);
        end else begin
          p = look_ix;
          for (i = 0; i < len; i++) begin
            queue_result(mirror_mem[p], 1'b0, i == len - 1);
            p = p + 1'b1;
          end
        end
      end
      FN_POP_RUN: begin
        if (len == 0 || len > MAX_RUN || stored_bytes() < len) begin
          queue_result('0, 1'b1, 1'b1);
        end else begin
          for (i = 0; i < len; i++) begin
            p = front_ix;
            front_ix = front_ix + 1'b1;
            queue_result(mirror_mem[p], 1'b0, i == len - 1);
          end
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (mirror_mem[k]) mirror_mem[k] = '0;
      front_ix = '0;
      tail_ix  = '0;
      look_ix  = '0;
      expected_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          error_cnt++;
          $display("%0t: result transaction with none expected, expected nothing, actual %0d",
                   $time, rsp_i.data_out);
        end else begin
          oldest = expected_q.pop_front();
          compare_field("data_out", oldest.data_out, rsp_i.data_out);
          compare_field("status", oldest.status, rsp_i.status);
          compare_field("fill_count", oldest.fill_count, rsp_i.fill_count);
          compare_field("free_space", oldest.free_space, rsp_i.free_space);
          compare_field("last", oldest.last, rsp_i.last);
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_op(func_e'(req_i.func), req_i.data_in, req_i.run_length);
      end
    end
    errors_o  <= error_cnt;
    pending_o <= expected_q.size();
    fill_o    <= stored_bytes();
  end

endmodule

@@ test/testbench.sv @@
// Top of the byte ring FIFO testbench: clock, reset, request traffic and the verdict.
module testbench;
  import brf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned LONG_STALL    = 300;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HIGH_FILL     = 768;
  localparam int unsigned LOW_FILL      = 40;

  logic              clk_i;
  logic              rst_ni;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_idle_pct  = 0;
  int unsigned       stall_requests = 0;
  int unsigned       stall_served   = 0;
  int unsigned       stall_left     = 0;
  int unsigned       cycle_cnt      = 0;
  int unsigned       errors;
  int unsigned       pending;
  logic [FILL_W-1:0] fill_level;

  brf_req_if req_if ();
  brf_rsp_if rsp_if ();

  byte_ring_fifo_with_lookahead uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  brf_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending),
    .fill_o    (fill_level)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // A long stall is requested by bumping stall_requests; the count runs down here.
  always @(posedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served  <= stall_requests;
      stall_left    <= LONG_STALL;
      rsp_if.ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      rsp_if.ready  <= 1'b0;
    end else begin
      rsp_if.ready  <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic offer(input func_e f, input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= f;
    req_if.data_in    <= d;
    req_if.run_length <= n;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Steer towards pops when the store is nearly full and towards pushes when nearly empty.
  function automatic func_e pick_func(input int unsigned fill);
    int unsigned r;
    r = $urandom_range(99);
    if (fill > HIGH_FILL && r < 60) return FN_POP_RUN;
    if (fill < LOW_FILL && r < 50) return FN_PUSH;
    r = $urandom_range(99);
    if (r < 30) return FN_PUSH;
    if (r < 42) return FN_POP;
    if (r < 54) return FN_LA_READ;
    if (r < 62) return FN_LA_FRONT;
    if (r < 66) return FN_LA_ADV;
    if (r < 70) return FN_COMMIT;
    if (r < 84) return FN_PEEK_RUN;
    return FN_POP_RUN;
  endfunction

  function automatic logic [LEN_W-1:0] pick_run_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 78) return LEN_W'($urandom_range(1, 8));
    if (r < 92) return LEN_W'($urandom_range(9, MAX_RUN));
    if (r < 96) return '0;
    return LEN_W'($urandom_range(MAX_RUN + 1, 2 ** LEN_W - 1));
  endfunction

  task automatic send_random(input int unsigned count);
    func_e             f;
    logic [LEN_W-1:0]  n;
    repeat (count) begin
      f = pick_func(fill_level);
      n = (f == FN_POP_RUN && fill_level > HIGH_FILL) ? LEN_W'(MAX_RUN) : pick_run_len();
      offer(f, DATA_W'($urandom_range(255)), n);
    end
  endtask

  task automatic send_directed();
    offer(FN_POP, 8'h00, 7'd1);
    offer(FN_LA_READ, 8'h00, 7'd1);
    offer(FN_POP_RUN, 8'h00, 7'd1);
    offer(FN_PEEK_RUN, 8'h00, 7'd64);
    offer(FN_PEEK_RUN, 8'h00, 7'd0);
    offer(FN_POP_RUN, 8'h00, 7'd127);
    offer(FN_PUSH, 8'h00, 7'd1);
    offer(FN_PUSH, 8'hff, 7'd1);
    offer(FN_PUSH, 8'ha5, 7'd1);
    offer(FN_PUSH, 8'h5a, 7'd1);
    offer(FN_LA_READ, 8'h00, 7'd1);
    offer(FN_LA_ADV, 8'h00, 7'd1);
    offer(FN_LA_READ, 8'h00, 7'd1);
    offer(FN_PEEK_RUN, 8'h00, 7'd5);
    offer(FN_LA_FRONT, 8'h00, 7'd1);
    offer(FN_POP_RUN, 8'h00, 7'd5);
    offer(FN_POP_RUN, 8'h00, 7'd2);
    offer(FN_COMMIT, 8'h00, 7'd1);
    offer(FN_POP, 8'h00, 7'd1);
    offer(FN_LA_FRONT, 8'h00, 7'd1);
    // Moving the lookahead one past the tail and committing leaves the store full.
    repeat (4) offer(FN_LA_ADV, 8'h00, 7'd1);
    offer(FN_COMMIT, 8'h00, 7'd1);
    offer(FN_PUSH, 8'h77, 7'd1);
    offer(FN_POP, 8'h00, 7'd1);
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = FN_PUSH;
    req_if.data_in    = '0;
    req_if.run_length = 7'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct <= 77;
    send_directed();
    send_random(150);
    drain();

    send_idle_pct = 77;
    recv_idle_pct <= 27;
    send_random(150);
    drain();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    stall_requests <= stall_requests + 1;
    send_random(60);
    send_random(90);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/brf_pkg.sv
src/brf_if.sv
src/brf_store.sv
src/byte_ring_fifo_with_lookahead.sv
test/brf_checker.sv
test/testbench.sv
